// ===== rtl/twcc_pkg.sv =====
// Shared types, codes and chunk helpers for the transport-wide CC feedback decoder.
// No dependencies; twcc_feedback_decoder imports this package.
package twcc_pkg;

    localparam int unsigned MAX_CHUNKS_DEF = 64;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CHUNKS,
        PH_DELTAS,
        PH_DONE,
        PH_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_WALK,
        SQ_EVAL,
        SQ_EMIT
    } seq_state_t;

    localparam logic [1:0] SYM_SMALL = 2'd1;
    localparam logic [1:0] SYM_LARGE = 2'd2;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_EARLY_END = 2'd2;

    // header byte positions
    localparam logic [3:0] HDR_SEQ_START = 4'd4;
    localparam logic [3:0] HDR_CNT_START = 4'd6;
    localparam logic [3:0] HDR_REF_START = 4'd8;
    localparam logic [3:0] HDR_FB_IDX    = 4'd11;

    localparam logic [15:0] REF_TIME_SCALE = 16'd64000;
    localparam logic [15:0] DELTA_SCALE    = 16'd250;

    function automatic logic [12:0] chunk_len(logic [15:0] c);
        if (!c[15]) begin
            return c[12:0];
        end else if (c[14]) begin
            return 13'd7;
        end else begin
            return 13'd14;
        end
    endfunction

    // p must lie below chunk_len(c)
    function automatic logic [1:0] chunk_sym(logic [15:0] c, logic [12:0] p);
        logic [3:0] sh2;
        logic [3:0] sh1;
        sh2 = 4'd12 - {p[2:0], 1'b0};
        sh1 = 4'd13 - p[3:0];
        if (!c[15]) begin
            return c[14:13];
        end else if (c[14]) begin
            return 2'(c >> sh2);
        end else begin
            return {1'b0, c[sh1]};
        end
    endfunction

endpackage

// ===== rtl/twcc_if.sv =====
// Valid/ready channel interfaces for FCI bytes in and packet reports out.
// Depends on nothing.
interface twcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] fci_byte;
    logic       last_byte;

    modport source (output valid, output fci_byte, output last_byte, input ready);
    modport sink   (input valid, input fci_byte, input last_byte, output ready);
endinterface

interface twcc_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        media_ssrc;
    logic [7:0]         feedback_count;
    logic [15:0]        packet_seq;
    logic [1:0]         packet_status;
    logic signed [47:0] arrival_time_us;
    logic [1:0]         error_code;
    logic               final_report;

    modport source (output valid, output media_ssrc, output feedback_count,
                    output packet_seq, output packet_status, output arrival_time_us,
                    output error_code, output final_report, input ready);
    modport sink   (input valid, input media_ssrc, input feedback_count,
                    input packet_seq, input packet_status, input arrival_time_us,
                    input error_code, input final_report, output ready);
endinterface

// ===== rtl/twcc_chunk_mem.sv =====
// Packet chunk store: one write port, one registered read port.
// Depends on nothing.
module twcc_chunk_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);

    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/twcc_feedback_decoder.sv =====
// Top level of the transport-wide CC feedback decoder: header capture, chunk
// store and a sequencer that walks stored chunks. Uses twcc_pkg, twcc_if, twcc_chunk_mem.
//
//  channel  dir  payload
//  fci      in   fci_byte[8], last_byte
//  report   out  media_ssrc, feedback_count, packet_seq, packet_status,
//                arrival_time_us, error_code, final_report
//
// Header, chunk and ignored bytes are taken in SQ_IDLE; a byte that yields a report
// then hands it to the output register in SQ_EMIT, waiting while that register
// still holds an unaccepted report. After the last chunk and each delta the walker
// runs, each step being SQ_WALK (address) then SQ_EVAL (registered read); a step is
// a lost run, one lost vector symbol, the move past a finished chunk or the stop on
// a received symbol. SQ_WALK alone ends a walk that finds nothing left.
// A small delta whose next received symbol is in the same chunk: IDLE, WALK, EVAL, EMIT.
// fci.ready is low while the walker or the hand-off runs.
// rst_n clears all control state asynchronously; the chunk store is not cleared.
module twcc_feedback_decoder #(
    parameter int unsigned MAX_CHUNKS = twcc_pkg::MAX_CHUNKS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    twcc_in_if.sink    fci,
    twcc_out_if.source report
);
    import twcc_pkg::*;

    localparam int unsigned AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);

    seq_state_t  sq_reg, sq_next;
    phase_t      phase_reg, phase_next;
    logic [3:0]  hdr_idx_reg, hdr_idx_next;
    logic [31:0] ssrc_reg, ssrc_next;
    logic [15:0] base_seq_reg, base_seq_next;
    logic [15:0] status_total_reg, status_total_next;
    logic [23:0] ref_time_reg, ref_time_next;
    logic [7:0]  fb_count_reg, fb_count_next;
    logic [CW-1:0] stored_reg, stored_next;
    logic [16:0] covered_reg, covered_next;
    logic [CW-1:0] rptr_reg, rptr_next;
    logic [12:0] sympos_reg, sympos_next;
    logic [15:0] cur_seq_reg, cur_seq_next;
    logic [15:0] left_reg, left_next;
    logic [47:0] rtime_reg, rtime_next;
    logic [8:0]  pend_reg, pend_next;
    logic [15:0] cur_chunk_reg, cur_chunk_next;
    logic        last_reg, last_next;
    logic        have_reg, have_next;
    logic [1:0]  err_reg, err_next;
    logic [15:0] rseq_reg, rseq_next;
    logic [1:0]  rst_reg, rst_next;
    logic [47:0] rtm_reg, rtm_next;

    logic        ov_reg, ov_next;
    logic [31:0] o_ssrc_reg, o_ssrc_next;
    logic [7:0]  o_fb_reg, o_fb_next;
    logic [15:0] o_seq_reg, o_seq_next;
    logic [1:0]  o_st_reg, o_st_next;
    logic [47:0] o_tm_reg, o_tm_next;
    logic [1:0]  o_err_reg, o_err_next;
    logic        o_fin_reg, o_fin_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [15:0]   mem_rdata;

    logic [1:0]  cur_sym;
    logic        emit_fire;

    twcc_chunk_mem #(.DEPTH(MAX_CHUNKS), .AW(AW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cur_sym   = chunk_sym(cur_chunk_reg, sympos_reg);
    assign fci.ready = (sq_reg == SQ_IDLE);
    assign emit_fire = (sq_reg == SQ_EMIT) && (!ov_reg || report.ready);

    assign report.valid           = ov_reg;
    assign report.media_ssrc      = o_ssrc_reg;
    assign report.feedback_count  = o_fb_reg;
    assign report.packet_seq      = o_seq_reg;
    assign report.packet_status   = o_st_reg;
    assign report.arrival_time_us = o_tm_reg;
    assign report.error_code      = o_err_reg;
    assign report.final_report    = o_fin_reg;

    always_comb
    begin
        logic [15:0] c;
        logic [12:0] len;
        logic [1:0]  s;
        logic [12:0] k;
        logic [15:0] n;
        logic [47:0] inc;
        logic        walk;
        logic [15:0] d;
        logic signed [25:0] dprod;
        logic [16:0] cov_sum;

        sq_next = sq_reg;
        phase_next = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        ssrc_next = ssrc_reg;
        base_seq_next = base_seq_reg;
        status_total_next = status_total_reg;
        ref_time_next = ref_time_reg;
        fb_count_next = fb_count_reg;
        stored_next = stored_reg;
        covered_next = covered_reg;
        rptr_next = rptr_reg;
        sympos_next = sympos_reg;
        cur_seq_next = cur_seq_reg;
        left_next = left_reg;
        rtime_next = rtime_reg;
        pend_next = pend_reg;
        cur_chunk_next = cur_chunk_reg;
        last_next = last_reg;
        have_next = have_reg;
        err_next = err_reg;
        rseq_next = rseq_reg;
        rst_next = rst_reg;
        rtm_next = rtm_reg;
        ov_next = ov_reg && !report.ready;
        o_ssrc_next = o_ssrc_reg;
        o_fb_next = o_fb_reg;
        o_seq_next = o_seq_reg;
        o_st_next = o_st_reg;
        o_tm_next = o_tm_reg;
        o_err_next = o_err_reg;
        o_fin_next = o_fin_reg;
        mem_we = 1'b0;
        mem_waddr = stored_reg[AW-1:0];
        mem_wdata = {pend_reg[7:0], fci.fci_byte};
        mem_raddr = rptr_reg[AW-1:0];
        c = mem_rdata;
        len = chunk_len(mem_rdata);
        s = chunk_sym(mem_rdata, sympos_reg);
        k = len - sympos_reg;
        n = 16'd1;
        inc = '0;
        walk = 1'b0;
        d = {pend_reg[7:0], fci.fci_byte};
        dprod = 26'($signed(d)) * 26'($signed({1'b0, DELTA_SCALE}));
        cov_sum = covered_reg + {4'd0, chunk_len(d)};

        case (sq_reg)
            SQ_IDLE:
            begin
                if (fci.valid)
                begin
                    last_next = fci.last_byte;
                    have_next = 1'b0;
                    err_next = ERR_NONE;
                    rseq_next = '0;
                    rst_next = '0;
                    rtm_next = '0;
                    case (phase_reg)
                        PH_HEADER:
                        begin
                            if (hdr_idx_reg < HDR_SEQ_START)
                                ssrc_next = {ssrc_reg[23:0], fci.fci_byte};
                            else if (hdr_idx_reg < HDR_CNT_START)
                                base_seq_next = {base_seq_reg[7:0], fci.fci_byte};
                            else if (hdr_idx_reg < HDR_REF_START)
                                status_total_next = {status_total_reg[7:0], fci.fci_byte};
                            else if (hdr_idx_reg < HDR_FB_IDX)
                                ref_time_next = {ref_time_reg[15:0], fci.fci_byte};
                            else
                                fb_count_next = fci.fci_byte;
                            hdr_idx_next = hdr_idx_reg + 4'd1;
                            if (hdr_idx_reg >= HDR_FB_IDX)
                            begin
                                hdr_idx_next = '0;
                                cur_seq_next = base_seq_reg;
                                left_next = status_total_reg;
                                rtime_next = {8'd0, 40'(ref_time_reg) * 40'(REF_TIME_SCALE)};
                                phase_next = (status_total_reg == '0) ? PH_DONE : PH_CHUNKS;
                            end
                        end
                        PH_CHUNKS:
                        begin
                            if (!pend_reg[8])
                            begin
                                pend_next = {1'b1, fci.fci_byte};
                            end
                            else
                            begin
                                pend_next = '0;
                                if (stored_reg >= CW'(MAX_CHUNKS))
                                begin
                                    phase_next = PH_SKIP;
                                    have_next = 1'b1;
                                    err_next = ERR_OVERFLOW;
                                end
                                else
                                begin
                                    mem_we = 1'b1;
                                    stored_next = stored_reg + CW'(1);
                                    covered_next = cov_sum;
                                    if (cov_sum >= {1'b0, status_total_reg})
                                    begin
                                        phase_next = PH_DELTAS;
                                        rptr_next = '0;
                                        sympos_next = '0;
                                        walk = 1'b1;
                                    end
                                end
                            end
                        end
                        PH_DELTAS:
                        begin
                            if (cur_sym != SYM_LARGE)
                            begin
                                inc = {32'd0, 16'(fci.fci_byte) * DELTA_SCALE};
                                rst_next = SYM_SMALL;
                                walk = 1'b1;
                            end
                            else if (!pend_reg[8])
                            begin
                                pend_next = {1'b1, fci.fci_byte};
                            end
                            else
                            begin
                                pend_next = '0;
                                inc = {{22{dprod[25]}}, dprod};
                                rst_next = SYM_LARGE;
                                walk = 1'b1;
                            end
                            if (walk)
                            begin
                                rtime_next = rtime_reg + inc;
                                have_next = 1'b1;
                                rseq_next = cur_seq_reg;
                                rtm_next = rtime_reg + inc;
                                cur_seq_next = cur_seq_reg + 16'd1;
                                left_next = left_reg - 16'd1;
                                sympos_next = sympos_reg + 13'd1;
                            end
                        end
                        default:
                        begin
                            // done or skipping: drop the byte
                        end
                    endcase
                    if (walk)
                        sq_next = SQ_WALK;
                    else if (have_next || fci.last_byte)
                        sq_next = SQ_EMIT;
                    else
                        sq_next = SQ_IDLE;
                end
            end
            SQ_WALK:
            begin
                if (left_reg == '0 || rptr_reg >= stored_reg)
                begin
                    left_next = '0;
                    phase_next = PH_DONE;
                    sq_next = (have_reg || last_reg) ? SQ_EMIT : SQ_IDLE;
                end
                else
                begin
                    sq_next = SQ_EVAL;
                end
            end
            SQ_EVAL:
            begin
                if (sympos_reg >= len)
                begin
                    rptr_next = rptr_reg + CW'(1);
                    sympos_next = '0;
                    sq_next = SQ_WALK;
                end
                else if (s == SYM_SMALL || s == SYM_LARGE)
                begin
                    cur_chunk_next = c;
                    sq_next = (have_reg || last_reg) ? SQ_EMIT : SQ_IDLE;
                end
                else
                begin
                    // skip the whole lost run at once; a vector chunk skips one lost symbol
                    if (!c[15])
                        n = ({3'd0, k} > left_reg) ? left_reg : {3'd0, k};
                    cur_seq_next = cur_seq_reg + n;
                    left_next = left_reg - n;
                    sympos_next = sympos_reg + n[12:0];
                    sq_next = SQ_WALK;
                end
            end
            SQ_EMIT:
            begin
                if (emit_fire)
                begin
                    ov_next = 1'b1;
                    o_ssrc_next = ssrc_reg;
                    o_fb_next = fb_count_reg;
                    o_seq_next = rseq_reg;
                    o_st_next = rst_reg;
                    o_tm_next = rtm_reg;
                    o_fin_next = last_reg;
                    o_err_next = err_reg;
                    if (last_reg)
                    begin
                        if (phase_reg != PH_DONE && phase_reg != PH_SKIP)
                            o_err_next = ERR_EARLY_END;
                        else if (!have_reg)
                            o_err_next = ERR_NONE;
                        phase_next = PH_HEADER;
                        hdr_idx_next = '0;
                        ssrc_next = '0;
                        base_seq_next = '0;
                        status_total_next = '0;
                        ref_time_next = '0;
                        fb_count_next = '0;
                        stored_next = '0;
                        covered_next = '0;
                        rptr_next = '0;
                        sympos_next = '0;
                        cur_seq_next = '0;
                        left_next = '0;
                        rtime_next = '0;
                        pend_next = '0;
                    end
                    sq_next = SQ_IDLE;
                end
            end
            default:
            begin
                sq_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg <= SQ_IDLE;
            phase_reg <= PH_HEADER;
            hdr_idx_reg <= '0;
            ssrc_reg <= '0;
            base_seq_reg <= '0;
            status_total_reg <= '0;
            ref_time_reg <= '0;
            fb_count_reg <= '0;
            stored_reg <= '0;
            covered_reg <= '0;
            rptr_reg <= '0;
            sympos_reg <= '0;
            cur_seq_reg <= '0;
            left_reg <= '0;
            rtime_reg <= '0;
            pend_reg <= '0;
            last_reg <= 1'b0;
            have_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            sq_reg <= sq_next;
            phase_reg <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            ssrc_reg <= ssrc_next;
            base_seq_reg <= base_seq_next;
            status_total_reg <= status_total_next;
            ref_time_reg <= ref_time_next;
            fb_count_reg <= fb_count_next;
            stored_reg <= stored_next;
            covered_reg <= covered_next;
            rptr_reg <= rptr_next;
            sympos_reg <= sympos_next;
            cur_seq_reg <= cur_seq_next;
            left_reg <= left_next;
            rtime_reg <= rtime_next;
            pend_reg <= pend_next;
            last_reg <= last_next;
            have_reg <= have_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_chunk_reg <= cur_chunk_next;
        err_reg <= err_next;
        rseq_reg <= rseq_next;
        rst_reg <= rst_next;
        rtm_reg <= rtm_next;
        o_ssrc_reg <= o_ssrc_next;
        o_fb_reg <= o_fb_next;
        o_seq_reg <= o_seq_next;
        o_st_reg <= o_st_next;
        o_tm_reg <= o_tm_next;
        o_err_reg <= o_err_next;
        o_fin_reg <= o_fin_next;
    end

    a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= CW'(MAX_CHUNKS))
        else $error("chunk count beyond store depth");

    a_delta_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_reg == SQ_IDLE && phase_reg == PH_DELTAS) |->
        (cur_sym == SYM_SMALL || cur_sym == SYM_LARGE))
        else $error("waiting for a delta on a lost symbol");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && last_reg) |=> (phase_reg == PH_HEADER && stored_reg == '0))
        else $error("packet state kept after final report");

    a_ready_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (fci.valid && fci.ready && phase_reg == PH_DELTAS && !pend_reg[8]
         && cur_sym == SYM_SMALL) |=> (sq_reg == SQ_WALK))
        else $error("small delta did not start the chunk walk");

endmodule
